FILE: src/b2bcd_pkg.sv
// ----------------------------------------------------------------------------
// b2bcd_pkg
// shared widths, pipeline sizing and the shift-add-3 helpers for the
// binary to packed bcd converter
// ----------------------------------------------------------------------------
package b2bcd_pkg;

  // field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DIGITS  = 10;
  localparam int unsigned BCD_W   = 4 * DIGITS;
  localparam int unsigned CNT_W   = 4;

  // dabble pipeline sizing: shift steps per stage and number of stages
  localparam int unsigned STEPS_PER_STG = 4;
  localparam int unsigned DAB_STG       = DATA_W / STEPS_PER_STG;
  // input stage, dabble stages, digit count stage
  localparam int unsigned NUM_STG       = DAB_STG + 2;

  // output bus layout
  localparam int unsigned OUT_FIELDS_W = BCD_W + CNT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // one shift-add-3 step: correct digits at five or more, then shift in a bit
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic             bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DIGITS; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // number of significant digits: position of the highest nonzero nibble
  function automatic logic [CNT_W-1:0] digit_count(input logic [BCD_W-1:0] bcd);
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        cnt = CNT_W'(d + 1);
      end
    end
    return cnt;
  endfunction

endpackage

FILE: src/binary_to_bcd_converter_unit.sv
// ----------------------------------------------------------------------------
// binary_to_bcd_converter_unit
// pipelined signed 32-bit binary to ten-digit packed bcd converter
// ----------------------------------------------------------------------------
// usage
//   input channel in_*: one signed 32-bit value per item on in_tdata.
//   output channel out_*: out_tdata[39:0] holds ten bcd nibbles, nibble 0
//   the least significant digit; out_tdata[43:40] holds the count of
//   significant digits. zero and negative values give all zero digits and
//   a count of zero.
//   an item passes through one capture stage, eight shift-add-3 stages of
//   four steps each and one digit count stage, and out_tvalid rises once
//   it reaches the digit count stage.
//   throughput is one item per cycle unless the receiver stalls; each stage
//   holds one item and the shift-add-3 chain is split evenly over the eight
//   middle stages.
//   a stalled receiver holds out_tdata stable; upstream stages keep filling
//   any empty slots, so in_tready drops only once every stage is full.
//   synchronous reset clears all stage valid bits; no item is in flight
//   afterwards and in_tready is high in the next cycle.
// ----------------------------------------------------------------------------
module binary_to_bcd_converter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // value (bits 31:0)
  input  logic [b2bcd_pkg::DATA_W-1:0]        in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // bcd_digits (bits 39:0), digit_count (bits 43:40), zero fill above
  output logic [b2bcd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready
);

  localparam int unsigned DATA_W  = b2bcd_pkg::DATA_W;
  localparam int unsigned BCD_W   = b2bcd_pkg::BCD_W;
  localparam int unsigned CNT_W   = b2bcd_pkg::CNT_W;
  localparam int unsigned STEPS   = b2bcd_pkg::STEPS_PER_STG;
  localparam int unsigned DAB_STG = b2bcd_pkg::DAB_STG;
  localparam int unsigned NUM_STG = b2bcd_pkg::NUM_STG;
  localparam int unsigned OUT_W   = b2bcd_pkg::OUT_TDATA_W;

  // stage valid bits; bin_r[k] sits in stage k, bcd_r[k] in stage k+1
  logic [NUM_STG-1:0] v_r;
  logic [DATA_W-1:0]  bin_r   [DAB_STG];
  logic [DATA_W-1:0]  bin_nxt [DAB_STG];
  logic [BCD_W-1:0]   bcd_r   [DAB_STG+1];
  logic [BCD_W-1:0]   bcd_nxt [DAB_STG+1];
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [NUM_STG-1:0] load;

  // per-stage load enables: a stage takes new data when empty or draining
  always_comb begin
    load[NUM_STG-1] = !v_r[NUM_STG-1] || out_tready;
    for (int s = NUM_STG - 2; s >= 0; s--) begin
      load[s] = !v_r[s] || load[s+1];
    end
  end

  assign in_tready = load[0];

  // capture stage and shift-add-3 stages, four steps each
  always_comb begin
    logic [BCD_W-1:0]  bcd;
    logic [DATA_W-1:0] b;
    // negative values convert as zero
    bin_nxt[0] = in_tdata[DATA_W-1] ? '0 : in_tdata;
    for (int k = 1; k < DAB_STG; k++) begin
      bin_nxt[k] = '0;
    end
    bcd = '0;
    b   = '0;
    for (int k = 0; k < DAB_STG; k++) begin
      // shifted value of the previous stage feeds this one
      if (k > 0) begin
        bin_nxt[k] = b;
      end
      b = bin_r[k];
      for (int j = 0; j < STEPS; j++) begin
        bcd = b2bcd_pkg::dabble_step(bcd, b[DATA_W-1]);
        b   = {b[DATA_W-2:0], 1'b0};
      end
      bcd_nxt[k] = bcd;
      bcd        = bcd_r[k];
    end
    // digit count stage
    bcd_nxt[DAB_STG] = bcd_r[DAB_STG-1];
    cnt_nxt          = b2bcd_pkg::digit_count(bcd_r[DAB_STG-1]);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (load[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int s = 1; s < NUM_STG; s++) begin
        if (load[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < DAB_STG; k++) begin
      if (load[k]) begin
        bin_r[k] <= bin_nxt[k];
      end
    end
    for (int k = 0; k <= DAB_STG; k++) begin
      if (load[k+1]) begin
        bcd_r[k] <= bcd_nxt[k];
      end
    end
    if (load[NUM_STG-1]) begin
      cnt_r <= cnt_nxt;
    end
  end

  // output bus
  assign out_tvalid = v_r[NUM_STG-1];
  assign out_tdata  = OUT_W'({cnt_r, bcd_r[DAB_STG]});

endmodule

FILE: src/b2bcd_checker.sv
// ----------------------------------------------------------------------------
// b2bcd_checker
// port-level checks for the binary to bcd converter, bound to the top level
// ----------------------------------------------------------------------------
module b2bcd_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [b2bcd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready
);

  localparam int unsigned DIGITS = b2bcd_pkg::DIGITS;
  localparam int unsigned BCD_W  = b2bcd_pkg::BCD_W;
  localparam int unsigned CNT_W  = b2bcd_pkg::CNT_W;

  logic [BCD_W-1:0] digits;
  logic [CNT_W-1:0] cnt;
  logic             digits_ok;
  logic             upper_zero;

  assign digits = out_tdata[BCD_W-1:0];
  assign cnt    = out_tdata[BCD_W +: CNT_W];

  // every nibble is a decimal digit, nothing above the count is set
  always_comb begin
    digits_ok  = 1'b1;
    upper_zero = 1'b1;
    for (int d = 0; d < DIGITS; d++) begin
      if (digits[4*d +: 4] > 4'd9) begin
        digits_ok = 1'b0;
      end
      if (d >= int'(cnt) && digits[4*d +: 4] != 4'd0) begin
        upper_zero = 1'b0;
      end
    end
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // digits are decimal and the count is in range
  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> digits_ok && cnt <= CNT_W'(DIGITS))
    else $error("bad bcd digit or digit count");

  // count marks the highest significant digit
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> upper_zero &&
                   (cnt == '0 || digits[4*(int'(cnt)-1) +: 4] != 4'd0))
    else $error("digit count does not match digits");

endmodule

bind binary_to_bcd_converter_unit b2bcd_checker u_b2bcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

FILE: dv/binary_to_bcd_converter_unit_tb.sv
// ----------------------------------------------------------------------------
// binary_to_bcd_converter_unit_tb
// self-checking testbench for the binary to packed bcd converter: directed
// edge values, a gap-free burst, a long receiver hold-off that fills the
// pipeline, then mixed-magnitude random values with random gaps on both
// sides; every result is checked against a behavioral digit predictor
// ----------------------------------------------------------------------------
module binary_to_bcd_converter_unit_tb;
  localparam int unsigned DATA_W      = b2bcd_pkg::DATA_W;
  localparam int unsigned DIGITS      = b2bcd_pkg::DIGITS;
  localparam int unsigned BCD_W       = b2bcd_pkg::BCD_W;
  localparam int unsigned CNT_W       = b2bcd_pkg::CNT_W;
  localparam int unsigned OUT_TDATA_W = b2bcd_pkg::OUT_TDATA_W;

  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 1490;
  localparam int unsigned BURST_ITEMS  = 200;
  localparam int unsigned FILL_ITEMS   = 40;

  typedef struct packed {
    logic [BCD_W-1:0] digits;
    logic [CNT_W-1:0] count;
  } bcd_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic [DATA_W-1:0]      in_tdata   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  bcd_result_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;

  binary_to_bcd_converter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected digits and count of one value, by repeated division
  function automatic bcd_result_t to_decimal_digits(input logic [DATA_W-1:0] value);
    bcd_result_t res;
    logic [DATA_W-1:0] rest;
    int cnt;
    res  = '0;
    cnt  = 0;
    rest = value;
    // negative values give no digits
    if (!value[DATA_W-1]) begin
      while (rest != 0 && cnt < DIGITS) begin
        res.digits[4*cnt +: 4] = 4'(rest % 10);
        rest = rest / 10;
        cnt++;
      end
    end
    res.count = CNT_W'(cnt);
    return res;
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // value with a random number of decimal digits or sign
  function automatic logic [DATA_W-1:0] rand_value();
    int unsigned mode;
    int unsigned k;
    logic [DATA_W-1:0] lim;
    mode = $urandom_range(0, 9);
    k    = $urandom_range(1, 9);
    lim  = 1;
    repeat (k) lim = lim * 10;
    case (mode)
      0, 1:    return $urandom();
      2, 3, 4: return $urandom() & 32'h7fff_ffff;
      5, 6, 7: return $urandom_range(0, lim - 1);
      8:       return -DATA_W'($urandom_range(1, 100));
      default: return ($urandom_range(0, 1) == 1) ? lim : lim - 1;
    endcase
  endfunction

  // send one item after a random gap, return once it is accepted
  task automatic send_value(input logic [DATA_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold the sender until every expected result has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // edge values and decade boundaries
  task automatic test_directed();
    logic [DATA_W-1:0] vals[$];
    vals = {32'd0, 32'd1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_fffe,
            32'd9, 32'd10, 32'd99, 32'd100, 32'd9999, 32'd10000, 32'd99999999,
            32'd100000000, 32'd999999999, 32'd1000000000, 32'd1999999999,
            32'd2000000000, 32'd1234567890, 32'h5555_5555, 32'h2aaa_aaaa};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // full-rate stream with no gaps on either side
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (BURST_ITEMS) send_value(rand_value());
    no_gaps = 1'b0;
  endtask

  // receiver holds off long enough for the pipeline to fill and stall
  task automatic test_backpressure();
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (FILL_ITEMS) send_value(rand_value());
    no_gaps  = 1'b0;
  endtask

  // mixed random values with random gaps
  task automatic test_random();
    repeat (RANDOM_ITEMS) send_value(rand_value());
  endtask

  // receiver: random stalls, or a long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // record accepted items, check results, watch for a hang
  always @(posedge clk) begin
    bcd_result_t exp_res;
    if (rst_n) begin
      if (in_tvalid && in_tready) pending_results.push_back(to_decimal_digits(in_tdata));
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: bcd_digits %h digit_count %0d",
                 out_tdata[BCD_W-1:0], out_tdata[BCD_W +: CNT_W]);
          fail_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_tdata[BCD_W-1:0] !== exp_res.digits) begin
            $error("bcd_digits: expected %h, actual %h", exp_res.digits,
                   out_tdata[BCD_W-1:0]);
            fail_count++;
          end
          if (out_tdata[BCD_W +: CNT_W] !== exp_res.count) begin
            $error("digit_count: expected %0d, actual %0d", exp_res.count,
                   out_tdata[BCD_W +: CNT_W]);
            fail_count++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // test sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drain();
    test_back_to_back();
    test_backpressure();
    wait_drain();
    test_random();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: binary_to_bcd_converter_unit.f
src/b2bcd_pkg.sv
src/binary_to_bcd_converter_unit.sv
src/b2bcd_checker.sv
dv/binary_to_bcd_converter_unit_tb.sv
